>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the caller-ID frame parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CIDFP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define CIDFP_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/cidfp_pkg.sv
// ----------------------------------------------------------------------------
// Caller-ID frame parser package
// Constants, codes and types shared by the parser modules.
// ----------------------------------------------------------------------------
package cidfp_pkg;

    // Framing bytes.
    localparam logic [7:0] SEIZE_BYTE = 8'h55;
    localparam logic [7:0] TYPE_SETUP = 8'h80;

    // Register reset values.
    localparam logic [7:0] MIN_SEIZURE_RESET = 8'd27;
    localparam logic [7:0] MAX_WRONG_RESET   = 8'd4;

    // Payload buffer; the widths below cover the largest buffer allowed.
    localparam int BUFFER_BYTES_DEFAULT = 64;
    localparam int ADDR_W = 6;
    localparam int LEN_W  = 7;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Register indexes on the configuration port.
    typedef enum logic
    {
        REG_MIN_SEIZURE = 1'b0,
        REG_MAX_WRONG   = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0]
    {
        PH_HUNT  = 3'd0,
        PH_SEIZE = 3'd1,
        PH_TYPE  = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4
    } phase_t;

    typedef enum logic [2:0]
    {
        KIND_CONSUMED = 3'd0,
        KIND_CODE     = 3'd1,
        KIND_LENGTH   = 3'd2,
        KIND_DATA     = 3'd3,
        KIND_EMPTY    = 3'd4
    } kind_t;

    typedef enum logic [1:0]
    {
        CMD_DONE  = 2'd0,
        CMD_STORE = 2'd1,
        CMD_FRAME = 2'd2
    } cmd_op_t;

    typedef enum logic [1:0]
    {
        B_IDLE = 2'd0,
        B_READ = 2'd1,
        B_EMIT = 2'd2
    } back_state_t;

    typedef enum logic [1:0]
    {
        ROLE_CODE   = 2'd0,
        ROLE_LENGTH = 2'd1,
        ROLE_DATA   = 2'd2
    } role_t;

    // One command from the front to the back.
    typedef struct packed
    {
        cmd_op_t           op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [LEN_W-1:0]  len;
    } cmd_t;

endpackage

>>> rtl/caller_id_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// Caller-ID frame parser unit
// Parses demodulated caller-ID bytes: seizure, message type, length, payload
// and checksum, and streams a good frame as code, length and data records.
//
//   Channel  Direction  Handshake             Payload
//   input    in         in_valid / in_ready   rx_byte[7:0]
//   output   out        out_valid / out_ready kind[2:0], value[7:0], last
//   config   in         APB psel / penable    paddr[2:0], pwdata, prdata
//
// An item is taken by the front end whenever the command queue has room; a
// byte that does not finish a good frame yields its single result through the
// queue and the output register. A good frame yields payload_length results
// (one if empty), paced by the registered read port of the payload memory.
// Reset clears all control state at once; the payload memory is not cleared.
// A stalled output backs up into the two-entry queue, then stalls the input.
// ----------------------------------------------------------------------------
module caller_id_frame_parser_unit
#(
    parameter int BUFFER_BYTES = cidfp_pkg::BUFFER_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Received byte channel.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    // Result channel.
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  value,
    output logic        last,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cidfp_pkg::*;

    logic [7:0] min_seizure_reg;
    logic [7:0] max_wrong_reg;
    logic       cfg_write;
    reg_idx_t   cfg_idx;
    logic [7:0] cfg_rdata;

    logic       queue_full;
    logic       queue_empty;
    logic       cmd_push;
    logic       cmd_pop;
    cmd_t       push_cmd;
    cmd_t       head_cmd;

    // Registers sit on word boundaries, so only the word address bit selects.
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_idx)
            REG_MIN_SEIZURE: cfg_rdata = min_seizure_reg;
            REG_MAX_WRONG:   cfg_rdata = max_wrong_reg;
            default:         cfg_rdata = 8'd0;
        endcase
    end

    assign prdata = {24'd0, cfg_rdata};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_seizure_reg <= MIN_SEIZURE_RESET;
            max_wrong_reg   <= MAX_WRONG_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_MIN_SEIZURE: min_seizure_reg <= pwdata[7:0];
                REG_MAX_WRONG:   max_wrong_reg   <= pwdata[7:0];
                default:         min_seizure_reg <= min_seizure_reg;
            endcase
        end
    end

    // The front end follows the framing and turns every item into one
    // command: consumed, store a payload byte, or emit a checked frame.
    cidfp_front
    #(
        .BUFFER_BYTES (BUFFER_BYTES)
    )
    u_front
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .rx_byte              (rx_byte),
        .min_seizure_count    (min_seizure_reg),
        .max_wrong_type_bytes (max_wrong_reg),
        .queue_full           (queue_full),
        .cmd_push             (cmd_push),
        .cmd                  (push_cmd)
    );

    // The queue keeps commands in order, so payload bytes of a following
    // frame are only written after the current frame has been read out.
    cidfp_cmd_fifo u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (cmd_pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty)
    );

    // The back end owns the payload memory and the output register.
    cidfp_back
    #(
        .BUFFER_BYTES (BUFFER_BYTES)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head_cmd    (head_cmd),
        .cmd_pop     (cmd_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .value       (value),
        .last        (last)
    );

endmodule

>>> rtl/cidfp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Caller-ID command queue
// Short first-in first-out queue of commands between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cidfp_cmd_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cidfp_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output cidfp_pkg::cmd_t head_cmd,
    output logic            empty
);
    import cidfp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `CIDFP_NEVER(a_no_push_when_full, clk, rst_n, push && full, "command pushed into a full queue")
    `CIDFP_NEVER(a_no_pop_when_empty, clk, rst_n, pop && empty, "command popped from an empty queue")

endmodule

>>> rtl/cidfp_front.sv
// ----------------------------------------------------------------------------
// Caller-ID front end
// Accepts received bytes, tracks the framing and issues one command per item.
// ----------------------------------------------------------------------------
module cidfp_front
#(
    parameter int BUFFER_BYTES = cidfp_pkg::BUFFER_BYTES_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      rx_byte,
    input  logic [7:0]      min_seizure_count,
    input  logic [7:0]      max_wrong_type_bytes,
    input  logic            queue_full,
    output logic            cmd_push,
    output cidfp_pkg::cmd_t cmd
);
    import cidfp_pkg::*;

    localparam logic [7:0] BUF_LIMIT = 8'(BUFFER_BYTES);

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [7:0]       counter_reg;
    logic [7:0]       counter_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic [7:0]       sum_add;
    logic [7:0]       counter_sat;
    logic             accept;

    assign in_ready    = !queue_full;
    assign accept      = in_valid && in_ready;
    assign cmd_push    = accept;
    assign sum_add     = sum_reg + rx_byte;
    assign counter_sat = (counter_reg == 8'hFF) ? counter_reg : counter_reg + 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        counter_next = counter_reg;
        len_next     = len_reg;
        sum_next     = sum_reg;
        cmd.op       = CMD_DONE;
        cmd.addr     = counter_reg[ADDR_W-1:0];
        cmd.data     = rx_byte;
        cmd.len      = len_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == SEIZE_BYTE)
                    begin
                        phase_next   = PH_SEIZE;
                        counter_next = 8'd1;
                    end
                end
                PH_SEIZE:
                begin
                    if (rx_byte == SEIZE_BYTE)
                    begin
                        counter_next = counter_sat;
                    end
                    else if (counter_reg >= min_seizure_count)
                    begin
                        counter_next = 8'd0;
                        if (rx_byte == TYPE_SETUP)
                        begin
                            sum_next   = rx_byte;
                            phase_next = PH_LEN;
                        end
                        else
                        begin
                            phase_next = PH_TYPE;
                        end
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_TYPE:
                begin
                    if (rx_byte == TYPE_SETUP)
                    begin
                        counter_next = 8'd0;
                        sum_next     = rx_byte;
                        phase_next   = PH_LEN;
                    end
                    else
                    begin
                        counter_next = counter_sat;
                        if (counter_sat >= max_wrong_type_bytes)
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                end
                PH_LEN:
                begin
                    if (rx_byte != TYPE_SETUP)
                    begin
                        if (rx_byte > BUF_LIMIT)
                        begin
                            phase_next = PH_HUNT;
                        end
                        else
                        begin
                            len_next   = rx_byte[LEN_W-1:0];
                            sum_next   = sum_add;
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (counter_reg < {1'b0, len_reg} && counter_reg < BUF_LIMIT)
                    begin
                        cmd.op       = CMD_STORE;
                        counter_next = counter_reg + 8'd1;
                        sum_next     = sum_add;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                        if (sum_add == 8'd0)
                        begin
                            counter_next = 8'd0;
                            cmd.op       = CMD_FRAME;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            counter_reg <= '0;
            len_reg     <= '0;
            sum_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            counter_reg <= counter_next;
            len_reg     <= len_next;
            sum_reg     <= sum_next;
        end
    end

endmodule

>>> rtl/cidfp_back.sv
// ----------------------------------------------------------------------------
// Caller-ID back end
// Executes commands: stores payload bytes, gives a consumed record per store or done
// command, and walks a checked frame as code, length and data records (an empty one as one empty record).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cidfp_back
#(
    parameter int BUFFER_BYTES = cidfp_pkg::BUFFER_BYTES_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            queue_empty,
    input  cidfp_pkg::cmd_t head_cmd,
    output logic            cmd_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2:0]      kind,
    output logic [7:0]      value,
    output logic            last
);
    import cidfp_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    logic [7:0]       payload_mem [BUFFER_BYTES];
    logic [7:0]       rdata_reg;
    logic             mem_we;

    back_state_t      state_reg;
    back_state_t      state_next;
    role_t            role_reg;
    role_t            role_next;
    logic [LEN_W-1:0] pos_reg;
    logic [LEN_W-1:0] pos_next;
    logic [LEN_W-1:0] pos_inc;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [7:0]       run_reg;
    logic [7:0]       run_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    kind_t            kind_reg;
    kind_t            kind_next;
    logic [7:0]       value_reg;
    logic [7:0]       value_next;
    logic             last_reg;
    logic             last_next;
    logic             out_free;
    logic             walk_last;

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign last      = last_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign pos_inc   = pos_reg + LEN_W'(1);
    assign walk_last = (pos_inc == len_reg);

    always_comb
    begin
        state_next     = state_reg;
        role_next      = role_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        run_next       = run_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!queue_empty && out_free)
                begin
                    cmd_pop = 1'b1;
                    case (head_cmd.op)
                        CMD_FRAME:
                        begin
                            if (head_cmd.len == '0)
                            begin
                                out_valid_next = 1'b1;
                                kind_next      = KIND_EMPTY;
                                value_next     = 8'd0;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                pos_next   = '0;
                                len_next   = head_cmd.len;
                                role_next  = ROLE_CODE;
                                state_next = B_READ;
                            end
                        end
                        CMD_STORE:
                        begin
                            mem_we         = 1'b1;
                            out_valid_next = 1'b1;
                            kind_next      = KIND_CONSUMED;
                            value_next     = 8'd0;
                            last_next      = 1'b1;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_CONSUMED;
                            value_next     = 8'd0;
                            last_next      = 1'b1;
                        end
                    endcase
                end
            end
            B_READ:
            begin
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = rdata_reg;
                    last_next      = walk_last;
                    pos_next       = pos_inc;
                    state_next     = walk_last ? B_IDLE : B_READ;
                    case (role_reg)
                        ROLE_CODE:
                        begin
                            kind_next = KIND_CODE;
                            role_next = ROLE_LENGTH;
                        end
                        ROLE_LENGTH:
                        begin
                            kind_next = KIND_LENGTH;
                            run_next  = rdata_reg;
                            role_next = (rdata_reg == 8'd0) ? ROLE_CODE : ROLE_DATA;
                        end
                        default:
                        begin
                            kind_next = KIND_DATA;
                            run_next  = run_reg - 8'd1;
                            role_next = (run_reg == 8'd1) ? ROLE_CODE : ROLE_DATA;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            role_reg      <= ROLE_CODE;
            pos_reg       <= '0;
            len_reg       <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            role_reg      <= role_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    // Payload memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            payload_mem[head_cmd.addr[AW-1:0]] <= head_cmd.data;
        end
        if (state_reg == B_READ)
        begin
            rdata_reg <= payload_mem[pos_reg[AW-1:0]];
        end
    end

    `CIDFP_ASSERT(a_walk_in_range, clk, rst_n, (state_reg == B_EMIT) |-> (pos_reg < len_reg), "frame walk ran past the payload length")
    `CIDFP_ASSERT(a_store_gives_result, clk, rst_n, (cmd_pop && head_cmd.op == CMD_STORE) |=> (out_valid_reg && kind_reg == KIND_CONSUMED && last_reg), "stored byte gave no consumed result")
    `CIDFP_NEVER(a_walk_no_pop, clk, rst_n, cmd_pop && state_reg != B_IDLE, "command taken during a frame walk")

endmodule

>>> sim/tb_caller_id_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// Caller-ID frame parser unit testbench
// Feeds received bytes to the parser and checks every output record against
// a cycle-free prediction of the framing: seizure count, message type, length,
// payload, checksum and the code/length/data walk over a good payload. The
// configuration registers are rewritten between traffic phases, each phase
// with its own pattern of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_caller_id_frame_parser_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import cidfp_pkg::*;

    localparam int FRAME_CAP      = BUFFER_BYTES_DEFAULT;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;

    // One expected output record.
    typedef struct
    {
        kind_t      kind;
        logic [7:0] value;
        logic       last;
    } record_t;

    typedef logic [7:0] byte_q_t [$];

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  value;
    logic        last;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = 3'd0;
    logic [31:0] pwdata    = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    caller_id_frame_parser_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .value     (value),
        .last      (last),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Our own copy of the parser state and of its two registers, which start
    // at their reset values and follow every register write seen on the port.
    phase_t     parse_phase   = PH_HUNT;
    logic [7:0] run_count     = 8'd0;
    logic [6:0] frame_len     = 7'd0;
    logic [7:0] frame_sum     = 8'd0;
    logic [7:0] frame_store [FRAME_CAP];
    logic [7:0] min_seizure   = MIN_SEIZURE_RESET;
    logic [7:0] max_wrong     = MAX_WRONG_RESET;

    // Records still owed by the parser, oldest first.
    record_t    owed_records [$];

    int         mismatch_count = 0;
    int         bytes_taken    = 0;
    int         bytes_sent     = 0;
    int         reg_writes     = 0;
    int         quiet_cycles   = 0;
    int         sender_idle_pct = 0;
    int         receiver_stall_pct = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Queues the records of a good frame: the stored payload walked as code,
    // length and data runs. A length byte or a data run that would reach past
    // the payload end is simply cut there, so every stored byte comes out
    // exactly once. An empty payload gives a single empty-frame record.
    function automatic int queue_frame_records();
        int pos;
        int run;
        int produced;
        pos      = 0;
        produced = 0;
        if (frame_len == 0)
        begin
            owed_records.push_back('{KIND_EMPTY, 8'd0, 1'b0});
            return 1;
        end
        while (pos < frame_len)
        begin
            owed_records.push_back('{KIND_CODE, frame_store[pos], 1'b0});
            pos++;
            produced++;
            if (pos >= frame_len)
                break;
            run = frame_store[pos];
            owed_records.push_back('{KIND_LENGTH, frame_store[pos], 1'b0});
            pos++;
            produced++;
            while (run > 0 && pos < frame_len)
            begin
                owed_records.push_back('{KIND_DATA, frame_store[pos], 1'b0});
                pos++;
                produced++;
                run--;
            end
        end
        return produced;
    endfunction

    // Advances the parser copy by one accepted byte and queues the records
    // it causes. Any byte that does not close a good frame owes one record
    // of kind consumed; the final record of every byte carries last.
    function automatic void predict_byte(input logic [7:0] b);
        int produced;
        produced = 0;
        case (parse_phase)
            PH_HUNT:
            begin
                if (b == SEIZE_BYTE)
                begin
                    parse_phase = PH_SEIZE;
                    run_count   = 8'd1;
                end
            end
            PH_SEIZE:
            begin
                if (b == SEIZE_BYTE)
                begin
                    if (run_count != 8'hFF)
                        run_count++;
                end
                else if (run_count >= min_seizure)
                begin
                    run_count = 8'd0;
                    if (b == TYPE_SETUP)
                    begin
                        frame_sum   = b;
                        parse_phase = PH_LEN;
                    end
                    else
                        parse_phase = PH_TYPE;
                end
                else
                    parse_phase = PH_HUNT;
            end
            PH_TYPE:
            begin
                if (b == TYPE_SETUP)
                begin
                    run_count   = 8'd0;
                    frame_sum   = b;
                    parse_phase = PH_LEN;
                end
                else
                begin
                    if (run_count != 8'hFF)
                        run_count++;
                    if (run_count >= max_wrong)
                        parse_phase = PH_HUNT;
                end
            end
            PH_LEN:
            begin
                if (b != TYPE_SETUP)
                begin
                    if (b > FRAME_CAP)
                        parse_phase = PH_HUNT;
                    else
                    begin
                        frame_len   = b[6:0];
                        frame_sum   = frame_sum + b;
                        parse_phase = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                if (run_count < frame_len && run_count < FRAME_CAP)
                begin
                    frame_store[run_count] = b;
                    run_count++;
                    frame_sum = frame_sum + b;
                end
                else
                begin
                    parse_phase = PH_HUNT;
                    if (8'(frame_sum + b) == 8'd0)
                    begin
                        run_count = 8'd0;
                        produced  = queue_frame_records();
                    end
                end
            end
            default:
                parse_phase = PH_HUNT;
        endcase
        if (produced == 0)
            owed_records.push_back('{KIND_CONSUMED, 8'd0, 1'b0});
        owed_records[owed_records.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor, checker and watchdog
    // ------------------------------------------------------------------------

    // Everything is sampled at the rising edge, before the parser's own
    // registers move. Predictions are queued before the check, so the order
    // of records in the queue never depends on which handshake came first.
    always @(posedge clk)
    begin
        record_t want;
        bit      moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[2]))
                    REG_MIN_SEIZURE: min_seizure = pwdata[7:0];
                    REG_MAX_WRONG:   max_wrong   = pwdata[7:0];
                    default: ;
                endcase
                reg_writes++;
                moved = 1'b1;
            end
            if (in_valid && in_ready)
            begin
                predict_byte(rx_byte);
                bytes_taken++;
                moved = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                if (owed_records.size() == 0)
                begin
                    $error("unexpected record: kind %0d value %0h last %0b",
                           kind, value, last);
                    mismatch_count++;
                end
                else
                begin
                    want = owed_records.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", want.kind, kind);
                        mismatch_count++;
                    end
                    if (value !== want.value)
                    begin
                        $error("value: expected %0h, actual %0h", want.value, value);
                        mismatch_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, last);
                        mismatch_count++;
                    end
                end
            end
            // A run is stuck once nothing has moved on any channel for far
            // longer than the worst sender gap or receiver stall.
            if (moved)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // The receiver decides afresh at every falling edge whether to stall.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offers one byte and returns at the falling edge after it was taken.
    // Valid is left high on return, so a back-to-back item simply replaces
    // the payload; it is lowered only when the sender chooses to idle or waits for the parser to drain.
    task automatic send_byte(input logic [7:0] b);
        int seen;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        seen = bytes_taken;
        do
            @(negedge clk);
        while (bytes_taken == seen);
        bytes_sent++;
    endtask

    // Waits until every owed record has come out, then lets the parser
    // settle so that it is idle before a register write.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (owed_records.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Setup cycle, then access cycle; returns with psel low after the write
    // was seen, so that a following write starts with a fresh setup cycle.
    task automatic write_register(input reg_idx_t idx, input logic [7:0] val);
        int seen;
        seen = reg_writes;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (reg_writes == seen);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_registers(input logic [7:0] seize_cfg,
                                 input logic [7:0] wrong_cfg);
        wait_until_drained();
        write_register(REG_MIN_SEIZURE, seize_cfg);
        write_register(REG_MAX_WRONG, wrong_cfg);
    endtask

    // A whole frame: seizure bytes, optional wrong type bytes, the type byte
    // (optionally repeated in the length slot), length, payload, checksum.
    // The first wrong type byte must not look like a seizure byte, or it
    // would simply extend the seizure.
    task automatic send_frame(input int seizures, input int wrong_types,
                              input bit repeat_type, input byte_q_t payload,
                              input bit good_sum);
        logic [7:0] sum;
        logic [7:0] b;
        repeat (seizures) send_byte(SEIZE_BYTE);
        for (int i = 0; i < wrong_types; i++)
        begin
            do
                b = 8'($urandom);
            while (b == TYPE_SETUP || (i == 0 && b == SEIZE_BYTE));
            send_byte(b);
        end
        send_byte(TYPE_SETUP);
        if (repeat_type)
            send_byte(TYPE_SETUP);
        sum = TYPE_SETUP + 8'(payload.size());
        send_byte(8'(payload.size()));
        foreach (payload[i])
        begin
            send_byte(payload[i]);
            sum = sum + payload[i];
        end
        send_byte(good_sum ? 8'(0 - sum) : 8'(1 - sum));
    endtask

    // Random payload shaped like code/length/data runs; now and then a
    // length byte is large enough that the walk gets cut at the end.
    function automatic byte_q_t make_tlv_payload(input int len);
        byte_q_t p;
        int      run;
        while (p.size() < len)
        begin
            p.push_back(8'($urandom));
            run = ($urandom_range(7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
            p.push_back(8'(run));
            repeat (run) p.push_back(8'($urandom));
        end
        while (p.size() > len)
            void'(p.pop_back());
        return p;
    endfunction

    // Mostly short payloads, with the occasional long one up to the buffer.
    function automatic int pick_payload_length();
        if ($urandom_range(9) == 0)
            return $urandom_range(13, FRAME_CAP);
        return $urandom_range(0, 12);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Registers at their reset values: exactly the reset seizure count, and
    // as many wrong type bytes as the reset tolerance lets through.
    task automatic test_reset_registers();
        byte_q_t p;
        p = '{8'h02, 8'h03, 8'h31, 8'h32, 8'h33};
        send_frame(MIN_SEIZURE_RESET, MAX_WRONG_RESET, 1'b0, p, 1'b1);
    endtask

    // Everything that sends the parser back to hunting for a seizure.
    task automatic test_hunt_restarts();
        byte_q_t p;
        set_registers(8'd2, 8'd1);
        // Ordinary bytes while hunting, at both ends of the byte range.
        send_byte(8'h00);
        send_byte(8'hFF);
        // The seizure ends one byte short of the minimum.
        send_byte(SEIZE_BYTE);
        send_byte(TYPE_SETUP);
        // The first wrong type byte is free, the next one reaches the
        // tolerance of one, and the type byte that follows is then ordinary.
        send_byte(SEIZE_BYTE);
        send_byte(SEIZE_BYTE);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(TYPE_SETUP);
        // Lengths just above the buffer and at the top of the range.
        send_byte(SEIZE_BYTE);
        send_byte(SEIZE_BYTE);
        send_byte(TYPE_SETUP);
        send_byte(8'(FRAME_CAP + 1));
        send_byte(SEIZE_BYTE);
        send_byte(SEIZE_BYTE);
        send_byte(TYPE_SETUP);
        send_byte(8'hFF);
        // A checksum that is off by one drops the frame without a word.
        p = '{8'h07};
        send_frame(2, 0, 1'b0, p, 1'b0);
    endtask

    task automatic test_good_frames();
        byte_q_t p;
        set_registers(8'd1, 8'd255);
        // Empty payload with a good checksum.
        p = {};
        send_frame(1, 0, 1'b0, p, 1'b1);
        // A repeated type byte in the length slot, and a data run that
        // claims more bytes than are left.
        p = '{8'h01, 8'h05, 8'hAA, 8'hBB};
        send_frame(1, 1, 1'b1, p, 1'b1);
        // A payload that ends right after a code byte.
        p = '{8'h04, 8'h00, 8'h09};
        send_frame(1, 0, 1'b0, p, 1'b1);
        // Full buffer, with the field extremes in code, length and data.
        p = {};
        p.push_back(8'h00);
        p.push_back(8'hFF);
        repeat (FRAME_CAP - 3) p.push_back(8'hFF);
        p.push_back(8'h00);
        send_frame(1, 0, 1'b0, p, 1'b1);
    endtask

    // One phase of random traffic under one register setting and one
    // pattern of idling. Most of it is well-formed frames with random
    // content; the rest is broken framing and plain noise.
    task automatic run_traffic_phase(input int idle_pct, input int stall_pct,
                                     input logic [7:0] seize_cfg,
                                     input logic [7:0] wrong_cfg,
                                     input int budget);
        int         start;
        int         pick;
        int         wrong;
        logic [7:0] b;
        byte_q_t    p;
        set_registers(seize_cfg, wrong_cfg);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                wrong = 0;
                if ($urandom_range(3) == 0)
                    wrong = $urandom_range(1, (max_wrong < 3) ? max_wrong : 3);
                p = make_tlv_payload(pick_payload_length());
                send_frame(min_seizure + $urandom_range(0, 2), wrong,
                           ($urandom_range(4) == 0), p, 1'b1);
            end
            else if (pick < 80)
            begin
                p = make_tlv_payload(pick_payload_length());
                send_frame(min_seizure, 0, 1'b0, p, 1'b0);
            end
            else if (pick < 86)
            begin
                repeat (min_seizure) send_byte(SEIZE_BYTE);
                send_byte(TYPE_SETUP);
                b = 8'($urandom_range(FRAME_CAP + 1, 255));
                send_byte((b == TYPE_SETUP) ? 8'hFF : b);
            end
            else if (pick < 92)
            begin
                if (max_wrong <= 4)
                begin
                    // One wrong type byte more than is tolerated.
                    repeat (min_seizure) send_byte(SEIZE_BYTE);
                    repeat (max_wrong + 1) send_byte(8'h3C);
                    send_byte(TYPE_SETUP);
                end
                else if (min_seizure >= 2)
                begin
                    repeat (min_seizure - 1) send_byte(SEIZE_BYTE);
                    send_byte(TYPE_SETUP);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(0, 0, 8'd1, 8'd1, 15);
        run_traffic_phase(87, 0, 8'd3, 8'd255, 15);
        run_traffic_phase(0, 87, 8'd2, 8'd3, 15);
        run_traffic_phase(23, 23, 8'($urandom_range(1, 3)), 8'($urandom_range(1, 4)), 15);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_registers();
        test_hunt_restarts();
        test_good_frames();
        test_random_traffic();

        wait_until_drained();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && owed_records.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
